// File: rtl/core/dmxr_pkg.sv
package dmxr_pkg;

  localparam logic [2:0] FUNC_BYTE  = 3'd0;
  localparam logic [2:0] FUNC_BREAK = 3'd1;
  localparam logic [2:0] FUNC_READ  = 3'd2;
  localparam logic [2:0] FUNC_POLL  = 3'd3;
  localparam logic [2:0] FUNC_FILL  = 3'd4;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_FILL
  } state_t;

  typedef struct packed {
    logic       start;
    logic [7:0] value;
  } sweep_ctl_t;

  typedef struct packed {
    logic       busy;
    logic       last;
    logic [7:0] wdata;
  } sweep_st_t;

  // first field of the word sits in the highest bits
  typedef struct packed {
    logic [9:0] slot;
    logic [7:0] data_byte;
    logic [2:0] func;
  } in_item_t;

  typedef struct packed {
    logic [31:0] frame_count;
    logic        new_frame;
    logic [7:0]  read_value;
  } out_item_t;

endpackage

// File: rtl/core/dmxr_ram.sv
module dmxr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 513
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/dmxr_sweep.sv
module dmxr_sweep #(
  parameter int unsigned SLOTS = 513
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  dmxr_pkg::sweep_ctl_t     ctl,
  output dmxr_pkg::sweep_st_t      st,
  output logic [$clog2(SLOTS)-1:0] addr
);

  localparam int unsigned AW = $clog2(SLOTS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(SLOTS - 1);

  logic          busy_r, busy_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [7:0]    value_r, value_nxt;

  always_comb begin
    busy_nxt  = busy_r;
    addr_nxt  = addr_r;
    value_nxt = value_r;
    if (ctl.start) begin
      busy_nxt  = 1'b1;
      addr_nxt  = '0;
      value_nxt = ctl.value;
    end else if (busy_r) begin
      addr_nxt = addr_r + AW'(1);
      if (addr_r == LAST_ADDR) begin
        busy_nxt = 1'b0;
      end
    end
  end

  // reset starts a zero sweep over both stores
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b1;
      addr_r  <= '0;
      value_r <= '0;
    end else begin
      busy_r  <= busy_nxt;
      addr_r  <= addr_nxt;
      value_r <= value_nxt;
    end
  end

  // slot 0 carries the start code and is always written as zero by the sweep
  assign st.busy  = busy_r;
  assign st.last  = busy_r && (addr_r == LAST_ADDR);
  assign st.wdata = (addr_r == '0) ? 8'd0 : value_r;
  assign addr     = addr_r;

endmodule

// File: rtl/core/dmx512_double_buffer_receiver_unit.sv
// results: byte, break, poll and fill words give their result in the cycle after
// acceptance; read words pass the registered frame store read, then the output register
// throughput: one word per cycle while the output is not stalled; after a read word the input
// waits in the read state, and a fill word blocks the input while the sweep rewrites both stores
// reset: synchronous, active low; after reset the stores are cleared by the
// same sweep, during which no word is accepted
module dmx512_double_buffer_receiver_unit #(
  parameter int unsigned SLOTS = 513
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // func[2:0], data_byte[10:3], slot[20:11], zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // read_value[7:0], new_frame[8], frame_count[40:9], zero
);

  localparam int unsigned AW = $clog2(SLOTS);
  localparam logic [AW-1:0] LAST_POS = AW'(SLOTS - 1);
  localparam logic [10:0]   SLOTS_W  = 11'(SLOTS);

  dmxr_pkg::in_item_t   in_item;
  dmxr_pkg::out_item_t  out_item_r, out_item_nxt;
  dmxr_pkg::state_t     state_r, state_nxt;
  dmxr_pkg::sweep_ctl_t sweep_ctl;
  dmxr_pkg::sweep_st_t  sweep_st;
  logic [AW-1:0]        sweep_addr;

  logic          out_valid_r, out_valid_nxt;
  logic          active_b_r, active_b_nxt;
  logic [AW-1:0] wpos_r, wpos_nxt;
  logic [31:0]   frame_cnt_r, frame_cnt_nxt;
  logic          flag_r, flag_nxt;
  logic          rd_from_a_r, rd_from_a_nxt;
  logic          rd_ok_r, rd_ok_nxt;

  logic          in_fire, out_fire, byte_fire;
  logic          we_a, we_b;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata, rdata_a, rdata_b, rd_byte;

  assign in_item   = in_tdata[20:0];
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_tvalid && out_tready;
  assign byte_fire = in_fire && (in_item.func == dmxr_pkg::FUNC_BYTE);

  dmxr_sweep #(.SLOTS(SLOTS)) u_sweep (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (sweep_ctl),
    .st   (sweep_st),
    .addr (sweep_addr)
  );

  // sweep owns both write ports; otherwise a byte goes to the active store
  assign we_a  = sweep_st.busy || (byte_fire && !active_b_r);
  assign we_b  = sweep_st.busy || (byte_fire && active_b_r);
  assign waddr = sweep_st.busy ? sweep_addr : wpos_r;
  assign wdata = sweep_st.busy ? sweep_st.wdata : in_item.data_byte;

  dmxr_ram #(.WIDTH(8), .DEPTH(SLOTS)) u_store_a (
    .clk  (clk),
    .we   (we_a),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(in_item.slot[AW-1:0]),
    .rdata(rdata_a)
  );

  dmxr_ram #(.WIDTH(8), .DEPTH(SLOTS)) u_store_b (
    .clk  (clk),
    .we   (we_b),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(in_item.slot[AW-1:0]),
    .rdata(rdata_b)
  );

  assign rd_byte = rd_ok_r ? (rd_from_a_r ? rdata_a : rdata_b) : 8'd0;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dmxr_pkg::ST_CLEAR: if (sweep_st.last) state_nxt = dmxr_pkg::ST_IDLE;
      dmxr_pkg::ST_FILL:  if (sweep_st.last) state_nxt = dmxr_pkg::ST_IDLE;
      dmxr_pkg::ST_READ:  state_nxt = dmxr_pkg::ST_IDLE;
      dmxr_pkg::ST_IDLE: begin
        if (in_fire && in_item.func == dmxr_pkg::FUNC_READ) begin
          state_nxt = dmxr_pkg::ST_READ;
        end else if (in_fire && in_item.func == dmxr_pkg::FUNC_FILL) begin
          state_nxt = dmxr_pkg::ST_FILL;
        end
      end
      default: state_nxt = dmxr_pkg::ST_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    in_tready       = 1'b0;
    sweep_ctl.start = 1'b0;
    sweep_ctl.value = in_item.data_byte;
    unique case (state_r)
      dmxr_pkg::ST_IDLE: begin
        in_tready       = !out_valid_r || out_tready;
        sweep_ctl.start = in_tvalid && (!out_valid_r || out_tready) &&
                          (in_item.func == dmxr_pkg::FUNC_FILL);
      end
      dmxr_pkg::ST_CLEAR, dmxr_pkg::ST_READ, dmxr_pkg::ST_FILL: begin
        in_tready = 1'b0;
      end
      default: in_tready = 1'b0;
    endcase
  end

  // item state and result
  always_comb begin
    active_b_nxt  = active_b_r;
    wpos_nxt      = wpos_r;
    frame_cnt_nxt = frame_cnt_r;
    flag_nxt      = flag_r;
    rd_from_a_nxt = rd_from_a_r;
    rd_ok_nxt     = rd_ok_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
    if (state_r == dmxr_pkg::ST_READ) begin
      out_valid_nxt           = 1'b1;
      out_item_nxt.read_value = rd_byte;
      out_item_nxt.new_frame  = 1'b0;
      out_item_nxt.frame_count = frame_cnt_r;
    end
    if (in_fire) begin
      case (in_item.func)
        dmxr_pkg::FUNC_BYTE: begin
          if (wpos_r != LAST_POS) begin
            wpos_nxt = wpos_r + AW'(1);
          end
        end
        dmxr_pkg::FUNC_BREAK: begin
          active_b_nxt  = !active_b_r;
          wpos_nxt      = '0;
          frame_cnt_nxt = frame_cnt_r + 32'd1;
          flag_nxt      = 1'b1;
        end
        dmxr_pkg::FUNC_READ: begin
          rd_from_a_nxt = active_b_r;
          rd_ok_nxt     = ({1'b0, in_item.slot} < SLOTS_W);
        end
        dmxr_pkg::FUNC_POLL: begin
          flag_nxt = 1'b0;
        end
        default: begin
        end
      endcase
      if (in_item.func != dmxr_pkg::FUNC_READ) begin
        out_valid_nxt            = 1'b1;
        out_item_nxt.read_value  = 8'd0;
        out_item_nxt.new_frame   = (in_item.func == dmxr_pkg::FUNC_POLL) && flag_r;
        out_item_nxt.frame_count = frame_cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dmxr_pkg::ST_CLEAR;
      out_valid_r <= 1'b0;
      active_b_r  <= 1'b0;
      wpos_r      <= '0;
      frame_cnt_r <= '0;
      flag_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      active_b_r  <= active_b_nxt;
      wpos_r      <= wpos_nxt;
      frame_cnt_r <= frame_cnt_nxt;
      flag_r      <= flag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r  <= out_item_nxt;
    rd_from_a_r <= rd_from_a_nxt;
    rd_ok_r     <= rd_ok_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_item_r};

  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    sweep_st.busy |-> !in_tready)
    else $error("word accepted while stores are swept");

  a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dmxr_pkg::ST_READ) |-> !out_valid_r)
    else $error("read result would overwrite a pending word");

  a_wpos_range: assert property (@(posedge clk) disable iff (!rst_n)
    wpos_r <= LAST_POS)
    else $error("write position past last slot");

  a_break_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_item.func == dmxr_pkg::FUNC_BREAK) |=>
      (frame_cnt_r == $past(frame_cnt_r) + 32'd1) && flag_r)
    else $error("break did not count the frame");

  a_sweep_state: assert property (@(posedge clk) disable iff (!rst_n)
    sweep_st.busy |-> (state_r == dmxr_pkg::ST_CLEAR || state_r == dmxr_pkg::ST_FILL))
    else $error("sweep running outside clear or fill");

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int SLOTS = 513;
  localparam int CLK_HALF = 4;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [2:0] FUNC_LAST = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;

  dmx512_double_buffer_receiver_unit #(.SLOTS(SLOTS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #CLK_HALF clk = ~clk;

  // predicted receiver state
  logic [7:0]  frame_a [SLOTS];
  logic [7:0]  frame_b [SLOTS];
  logic        collect_in_b;
  logic [9:0]  wr_pos;
  logic [31:0] frames_seen;
  logic        frame_flag;

  dmxr_pkg::out_item_t pending_results[$];
  dmxr_pkg::out_item_t want, got;
  int          mismatch_count = 0;
  int          words_sent = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          sink_stall_pct = 0;

  function automatic dmxr_pkg::out_item_t predict_dmx_word(logic [2:0] func,
                                                           logic [7:0] data,
                                                           logic [9:0] slot);
    dmxr_pkg::out_item_t r;
    r = '0;
    case (func)
      dmxr_pkg::FUNC_BYTE: begin
        if (collect_in_b) frame_b[wr_pos] = data;
        else frame_a[wr_pos] = data;
        if (wr_pos < SLOTS - 1) wr_pos = wr_pos + 10'd1;
      end
      dmxr_pkg::FUNC_BREAK: begin
        collect_in_b = ~collect_in_b;
        wr_pos = '0;
        frames_seen = frames_seen + 32'd1;
        frame_flag = 1'b1;
      end
      dmxr_pkg::FUNC_READ: begin
        if (slot < SLOTS) r.read_value = collect_in_b ? frame_a[slot] : frame_b[slot];
      end
      dmxr_pkg::FUNC_POLL: begin
        r.new_frame = frame_flag;
        frame_flag = 1'b0;
      end
      dmxr_pkg::FUNC_FILL: begin
        for (int i = 0; i < SLOTS; i++) begin
          frame_a[i] = (i == 0) ? 8'h00 : data;
          frame_b[i] = (i == 0) ? 8'h00 : data;
        end
      end
      default: ;
    endcase
    r.frame_count = frames_seen;
    return r;
  endfunction

  task automatic send_word(input logic [2:0] func, input logic [7:0] data,
                           input logic [9:0] slot);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, slot, data, func};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(predict_dmx_word(func, data, slot));
    words_sent++;
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing pending: %h", out_tdata);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        got  = dmxr_pkg::out_item_t'(out_tdata[40:0]);
        if (got.read_value !== want.read_value) begin
          $error("read_value: expected %0d, got %0d", want.read_value, got.read_value);
          mismatch_count++;
        end
        if (got.new_frame !== want.new_frame) begin
          $error("new_frame: expected %0d, got %0d", want.new_frame, got.new_frame);
          mismatch_count++;
        end
        if (got.frame_count !== want.frame_count) begin
          $error("frame_count: expected %0d, got %0d", want.frame_count, got.frame_count);
          mismatch_count++;
        end
      end
    end
    out_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic test_after_reset();
    send_word(dmxr_pkg::FUNC_READ, 8'h00, 10'd0);
    send_word(dmxr_pkg::FUNC_READ, 8'h00, 10'(SLOTS - 1));
    send_word(dmxr_pkg::FUNC_READ, 8'h00, 10'(SLOTS));
    send_word(dmxr_pkg::FUNC_READ, 8'hff, 10'h3ff);
    send_word(dmxr_pkg::FUNC_POLL, 8'h00, 10'd0);
    // unused codes must change nothing
    for (logic [3:0] f = 4'(dmxr_pkg::FUNC_FILL) + 4'd1; f <= {1'b0, FUNC_LAST}; f++)
      send_word(f[2:0], 8'hff, 10'h3ff);
  endtask

  task automatic test_frame_capture();
    send_word(dmxr_pkg::FUNC_BYTE, 8'h00, 10'd0);
    send_word(dmxr_pkg::FUNC_BYTE, 8'hff, 10'd0);
    send_word(dmxr_pkg::FUNC_BYTE, 8'ha5, 10'd0);
    send_word(dmxr_pkg::FUNC_BYTE, 8'h5a, 10'd0);
    send_word(dmxr_pkg::FUNC_BREAK, 8'h00, 10'd0);
    send_word(dmxr_pkg::FUNC_POLL, 8'h00, 10'd0);
    send_word(dmxr_pkg::FUNC_POLL, 8'h00, 10'd0);
    for (int s = 0; s < 5; s++) send_word(dmxr_pkg::FUNC_READ, 8'h00, 10'(s));
  endtask

  task automatic test_fill();
    send_word(dmxr_pkg::FUNC_FILL, 8'hff, 10'd0);
    send_word(dmxr_pkg::FUNC_READ, 8'h00, 10'd0);
    send_word(dmxr_pkg::FUNC_READ, 8'h00, 10'd1);
    send_word(dmxr_pkg::FUNC_READ, 8'h00, 10'(SLOTS - 1));
    send_word(dmxr_pkg::FUNC_BREAK, 8'h00, 10'd0);
    send_word(dmxr_pkg::FUNC_READ, 8'h00, 10'd7);
  endtask

  // bytes past the last slot keep overwriting it
  task automatic test_overlong_frame();
    send_word(dmxr_pkg::FUNC_BREAK, 8'h00, 10'd0);
    for (int i = 0; i < SLOTS + 6; i++)
      send_word(dmxr_pkg::FUNC_BYTE, 8'($urandom_range(255)), 10'd0);
    send_word(dmxr_pkg::FUNC_BREAK, 8'h00, 10'd0);
    send_word(dmxr_pkg::FUNC_READ, 8'h00, 10'd0);
    send_word(dmxr_pkg::FUNC_READ, 8'h00, 10'(SLOTS - 2));
    send_word(dmxr_pkg::FUNC_READ, 8'h00, 10'(SLOTS - 1));
    send_word(dmxr_pkg::FUNC_READ, 8'h00, 10'(SLOTS));
  endtask

  task automatic test_random_traffic(input int words);
    int goal, n, k, pick;
    goal = words_sent + words;
    while (words_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 4) begin
        send_word(dmxr_pkg::FUNC_FILL, 8'($urandom_range(255)), 10'($urandom_range(1023)));
      end else if (pick < 18) begin
        send_word(3'($urandom_range(7)), 8'($urandom_range(255)), 10'($urandom_range(1023)));
      end else begin
        // frame, completion, poll and read-back
        n = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(12);
        send_word(dmxr_pkg::FUNC_BREAK, 8'($urandom_range(255)), 10'($urandom_range(1023)));
        for (int i = 0; i < n; i++)
          send_word(dmxr_pkg::FUNC_BYTE, 8'($urandom_range(255)), 10'($urandom_range(1023)));
        if ($urandom_range(7) != 0)
          send_word(dmxr_pkg::FUNC_BREAK, 8'($urandom_range(255)),
                    10'($urandom_range(1023)));
        send_word(dmxr_pkg::FUNC_POLL, 8'($urandom_range(255)), 10'($urandom_range(1023)));
        k = $urandom_range(4, 1);
        for (int i = 0; i < k; i++) begin
          if ($urandom_range(4) != 0)
            send_word(dmxr_pkg::FUNC_READ, 8'($urandom_range(255)),
                      10'($urandom_range(n + 1)));
          else
            send_word(dmxr_pkg::FUNC_READ, 8'($urandom_range(255)),
                      10'($urandom_range(1023)));
        end
      end
    end
  endtask

  task automatic set_idling(input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    sink_stall_pct = stall_pct;
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      frame_a[i] = 8'h00;
      frame_b[i] = 8'h00;
    end
    collect_in_b = 1'b0;
    wr_pos       = '0;
    frames_seen  = '0;
    frame_flag   = 1'b0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    set_idling(0, 0);
    test_after_reset();
    test_frame_capture();
    test_fill();

    test_random_traffic(100);
    set_idling(60, 0);
    test_random_traffic(100);
    set_idling(0, 60);
    test_random_traffic(100);
    set_idling(13, 13);
    test_overlong_frame();
    test_random_traffic(100);

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
